@@ hdl/hdzs_pkg.sv @@
package hdzs_pkg;

  // Widths of the reading, timestamp, delay, log value and configuration fields
  localparam int unsigned RdW   = 14;
  localparam int unsigned TsW   = 32;
  localparam int unsigned DlyW  = 16;
  localparam int unsigned LogW  = 8;
  localparam int unsigned CfgAw = 3;
  localparam int unsigned CfgDw = 16;

  // Divide by 50 as multiply by ceil(2^18 / 50) and shift; exact for 14-bit readings
  localparam int unsigned       LogShift = 18;
  localparam logic [12:0]       LogRecip = 13'd5243;
  localparam int unsigned       LogProdW = RdW + 13;
  localparam int unsigned       LogQW    = LogProdW - LogShift;

  // Zone status codes
  typedef enum logic [2:0] {
    CODE_OK    = 3'd0,
    CODE_FIRE  = 3'd1,
    CODE_OPEN  = 3'd2,
    CODE_SHORT = 3'd3,
    CODE_OTHER = 3'd4
  } code_e;

  // Configuration register indexes
  typedef enum logic [CfgAw-1:0] {
    REG_OK_LOW      = 3'd0,
    REG_OK_HIGH     = 3'd1,
    REG_FIRE_LEVEL  = 3'd2,
    REG_OPEN_LEVEL  = 3'd3,
    REG_SHORT_LOW   = 3'd4,
    REG_SHORT_HIGH  = 3'd5,
    REG_FIRE_DELAY  = 3'd6,
    REG_TROUB_DELAY = 3'd7
  } reg_idx_e;

  // Reset values of the configuration registers
  localparam logic [RdW-1:0]  RstOkLow      = 14'd4000;
  localparam logic [RdW-1:0]  RstOkHigh     = 14'd8000;
  localparam logic [RdW-1:0]  RstFireLevel  = 14'd2000;
  localparam logic [RdW-1:0]  RstOpenLevel  = 14'd12000;
  localparam logic [RdW-1:0]  RstShortLow   = 14'd2500;
  localparam logic [RdW-1:0]  RstShortHigh  = 14'd4000;
  localparam logic [DlyW-1:0] RstFireDelay  = 16'd500;
  localparam logic [DlyW-1:0] RstTroubDelay = 16'd250;

  // Thresholds and delays, as seen by the classifiers
  typedef struct packed {
    logic [RdW-1:0]  ok_low;
    logic [RdW-1:0]  ok_high;
    logic [RdW-1:0]  fire_level;
    logic [RdW-1:0]  open_level;
    logic [RdW-1:0]  short_low;
    logic [RdW-1:0]  short_high;
    logic [DlyW-1:0] fire_delay_ms;
    logic [DlyW-1:0] trouble_delay_ms;
  } cfg_t;

  // Per-zone timer and code state
  typedef struct packed {
    logic [TsW-1:0] since;
    code_e          status;
  } zone_st_t;

endpackage

@@ hdl/hdzs_cfg.sv @@
module hdzs_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hdzs_pkg::CfgAw-1:0] cfg_idx_i,
  input  logic [hdzs_pkg::CfgDw-1:0] cfg_data_i,
  output hdzs_pkg::cfg_t             cfg_o
);
  import hdzs_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode the write index onto one register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_OK_LOW:      cfg_d.ok_low           = cfg_data_i[RdW-1:0];
        REG_OK_HIGH:     cfg_d.ok_high          = cfg_data_i[RdW-1:0];
        REG_FIRE_LEVEL:  cfg_d.fire_level       = cfg_data_i[RdW-1:0];
        REG_OPEN_LEVEL:  cfg_d.open_level       = cfg_data_i[RdW-1:0];
        REG_SHORT_LOW:   cfg_d.short_low        = cfg_data_i[RdW-1:0];
        REG_SHORT_HIGH:  cfg_d.short_high       = cfg_data_i[RdW-1:0];
        REG_FIRE_DELAY:  cfg_d.fire_delay_ms    = cfg_data_i[DlyW-1:0];
        REG_TROUB_DELAY: cfg_d.trouble_delay_ms = cfg_data_i[DlyW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ok_low           <= RstOkLow;
      cfg_q.ok_high          <= RstOkHigh;
      cfg_q.fire_level       <= RstFireLevel;
      cfg_q.open_level       <= RstOpenLevel;
      cfg_q.short_low        <= RstShortLow;
      cfg_q.short_high       <= RstShortHigh;
      cfg_q.fire_delay_ms    <= RstFireDelay;
      cfg_q.trouble_delay_ms <= RstTroubDelay;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/hdzs_zone.sv @@
module hdzs_zone (
  input  logic [hdzs_pkg::RdW-1:0]  filt_i,
  input  logic [hdzs_pkg::RdW-1:0]  raw_i,
  input  logic [hdzs_pkg::TsW-1:0]  now_i,
  input  hdzs_pkg::cfg_t            cfg_i,
  input  hdzs_pkg::zone_st_t        st_i,
  input  logic                      latch_i,
  output hdzs_pkg::zone_st_t        st_o,
  output logic                      latch_o,
  output logic [hdzs_pkg::LogW-1:0] log_o
);
  import hdzs_pkg::*;

  logic                is_ok;
  logic                is_fire;
  logic                is_open;
  logic                is_short;
  logic                is_other;
  logic [TsW-1:0]      elapsed;
  logic                fire_due;
  logic                troub_due;
  logic [LogProdW-1:0] prod;
  logic [LogQW-1:0]    quot;

  // Region tests; both readings have to agree
  assign is_ok    = (filt_i >= cfg_i.ok_low) && (filt_i < cfg_i.ok_high) &&
                    (raw_i >= cfg_i.ok_low) && (raw_i < cfg_i.ok_high);
  assign is_fire  = (filt_i <= cfg_i.fire_level) && (raw_i <= cfg_i.fire_level);
  assign is_open  = (filt_i >= cfg_i.open_level) && (raw_i >= cfg_i.open_level);
  assign is_short = (filt_i >= cfg_i.short_low) && (filt_i < cfg_i.short_high) &&
                    (raw_i >= cfg_i.short_low) && (raw_i < cfg_i.short_high);
  assign is_other = (filt_i > cfg_i.fire_level) && (raw_i > cfg_i.fire_level);

  // Zone timer, modulo 2^32
  assign elapsed   = now_i - st_i.since;
  assign fire_due  = elapsed > {{(TsW-DlyW){1'b0}}, cfg_i.fire_delay_ms};
  assign troub_due = elapsed > {{(TsW-DlyW){1'b0}}, cfg_i.trouble_delay_ms};

  // Classify in priority order; keep code and timer when nothing fires
  always_comb begin
    st_o    = st_i;
    latch_o = latch_i;
    if (is_ok) begin
      st_o.status = CODE_OK;
      st_o.since  = now_i;
    end else if (is_fire) begin
      if (latch_i) begin
        st_o.status = CODE_FIRE;
      end else if (fire_due) begin
        st_o.status = CODE_FIRE;
        st_o.since  = now_i;
        latch_o     = 1'b1;
      end
    end else if (is_open) begin
      if (troub_due) begin
        st_o.status = CODE_OPEN;
        st_o.since  = now_i;
      end
    end else if (is_short) begin
      if (troub_due) begin
        st_o.status = CODE_SHORT;
        st_o.since  = now_i;
      end
    end else if (is_other) begin
      if (troub_due) begin
        st_o.status = CODE_OTHER;
        st_o.since  = now_i;
      end
    end
  end

  // Filtered reading / 50, saturated to a byte
  assign prod  = LogProdW'(filt_i) * LogProdW'(LogRecip);
  assign quot  = prod[LogProdW-1:LogShift];
  assign log_o = (quot > LogQW'({LogW{1'b1}})) ? {LogW{1'b1}} : quot[LogW-1:0];

endmodule

@@ hdl/heat_detector_zone_supervisor.sv @@
// Channel    | Dir | Handshake                  | Payload
// s_axis     | in  | s_axis_tvalid_i/tready_o   | 96-bit tdata: two loops, timestamp, clear
// m_axis     | out | m_axis_tvalid_o/tready_i   | 32-bit tdata: codes, fire, flags, log values
// cfg        | in  | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// One sample per cycle sustained while the output is not stalled; the accepting edge
// loads the input register, and the sample is classified into the result register once
// that slot frees up. Zone one feeds the fire latch into zone two in the same cycle.
// Reset clears the zone timers, codes, fire latch and both valid flags.
// A stalled output holds its beat; the input register takes one more beat if it is
// empty, then the input side stalls until the output beat is taken.
module heat_detector_zone_supervisor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // zone1_filtered[13:0], zone1_raw[27:14], zone2_filtered[41:28],
  // zone2_raw[55:42], now_ms[87:56], clear_fire[88], zero fill [95:89]
  input  logic [95:0]                s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // zone1_code[2:0], zone2_code[5:3], fire_active[6], zone1_changed[7],
  // zone2_changed[8], zone1_log_value[16:9], zone2_log_value[24:17], zero fill [31:25]
  output logic [31:0]                m_axis_tdata_o,
  input  logic                       cfg_we_i,
  input  logic [hdzs_pkg::CfgAw-1:0] cfg_idx_i,
  input  logic [hdzs_pkg::CfgDw-1:0] cfg_data_i
);
  import hdzs_pkg::*;

  typedef struct packed {
    logic [RdW-1:0] z1_filt;
    logic [RdW-1:0] z1_raw;
    logic [RdW-1:0] z2_filt;
    logic [RdW-1:0] z2_raw;
    logic [TsW-1:0] now;
    logic           clr;
  } in_t;

  typedef struct packed {
    code_e           z1_code;
    code_e           z2_code;
    logic            fire;
    logic            z1_chg;
    logic            z2_chg;
    logic [LogW-1:0] z1_log;
    logic [LogW-1:0] z2_log;
  } res_t;

  cfg_t            cfg;
  in_t             in_q;
  logic            in_vld_q;
  res_t            res_q;
  res_t            res_d;
  logic            out_vld_q;
  zone_st_t        z1_q;
  zone_st_t        z2_q;
  zone_st_t        z1_d;
  zone_st_t        z2_d;
  logic            latch_q;
  logic            latch_z1;
  logic            latch_d;
  logic            latch_in;
  logic [LogW-1:0] z1_log;
  logic [LogW-1:0] z2_log;
  logic            adv;
  logic            s_hs;

  hdzs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Move a sample into the result register when that slot frees up
  assign adv             = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;
  assign s_hs            = s_axis_tvalid_i && s_axis_tready_o;

  // Capture the input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      in_q.z1_filt <= s_axis_tdata_i[13:0];
      in_q.z1_raw  <= s_axis_tdata_i[27:14];
      in_q.z2_filt <= s_axis_tdata_i[41:28];
      in_q.z2_raw  <= s_axis_tdata_i[55:42];
      in_q.now     <= s_axis_tdata_i[87:56];
      in_q.clr     <= s_axis_tdata_i[88];
    end
  end

  // Clear the latch ahead of classification
  assign latch_in = latch_q && !in_q.clr;

  hdzs_zone u_zone1 (
    .filt_i  (in_q.z1_filt),
    .raw_i   (in_q.z1_raw),
    .now_i   (in_q.now),
    .cfg_i   (cfg),
    .st_i    (z1_q),
    .latch_i (latch_in),
    .st_o    (z1_d),
    .latch_o (latch_z1),
    .log_o   (z1_log)
  );

  // Zone two sees a latch set by zone one in this sample
  hdzs_zone u_zone2 (
    .filt_i  (in_q.z2_filt),
    .raw_i   (in_q.z2_raw),
    .now_i   (in_q.now),
    .cfg_i   (cfg),
    .st_i    (z2_q),
    .latch_i (latch_z1),
    .st_o    (z2_d),
    .latch_o (latch_d),
    .log_o   (z2_log)
  );

  // Assemble the result; the last reported code always equals the stored code
  always_comb begin
    res_d.z1_code = z1_d.status;
    res_d.z2_code = z2_d.status;
    res_d.fire    = latch_d;
    res_d.z1_chg  = z1_d.status != z1_q.status;
    res_d.z2_chg  = z2_d.status != z2_q.status;
    res_d.z1_log  = z1_log;
    res_d.z2_log  = z2_log;
  end

  // Advance zone state and the latch with each classified sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z1_q.since  <= '0;
      z1_q.status <= CODE_OK;
      z2_q.since  <= '0;
      z2_q.status <= CODE_OK;
      latch_q     <= 1'b0;
    end else if (adv) begin
      z1_q    <= z1_d;
      z2_q    <= z2_d;
      latch_q <= latch_d;
    end
  end

  // Result register; hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready_i) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0, res_q.z2_log, res_q.z1_log, res_q.z2_chg, res_q.z1_chg,
                            res_q.fire, res_q.z2_code, res_q.z1_code};

endmodule

@@ hdl/hdzs_checker.sv @@
module hdzs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);
  import hdzs_pkg::*;

  logic out_hs;

  assign out_hs = m_axis_tvalid_o && m_axis_tready_i;

  // A stalled output beat holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output beat changed while stalled");

  // An open output side never stalls the input side
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output ready");

  // Codes stay within the defined set
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[2:0] <= 3'(CODE_OTHER)) &&
                        (m_axis_tdata_o[5:3] <= 3'(CODE_OTHER)))
    else $error("zone code out of range");

  // On back-to-back beats the change flags follow the code difference
  a_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && $past(out_hs) |->
      (m_axis_tdata_o[7] == (m_axis_tdata_o[2:0] != $past(m_axis_tdata_o[2:0]))) &&
      (m_axis_tdata_o[8] == (m_axis_tdata_o[5:3] != $past(m_axis_tdata_o[5:3]))))
    else $error("change flag disagrees with code sequence");

endmodule

bind heat_detector_zone_supervisor hdzs_checker u_hdzs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
